// ===== rtl/f2p_pkg.sv =====
// ----------------------------------------------------------------------------
// f2p_pkg
// Shared types, sample-size codes and helpers for the float to PCM packer.
// ----------------------------------------------------------------------------
package f2p_pkg;

    // Sample-size codes (bytes per output sample)
    localparam logic [2:0] CNT_U8    = 3'd1;
    localparam logic [2:0] CNT_S16   = 3'd2;
    localparam logic [2:0] CNT_S24   = 3'd3;
    localparam logic [2:0] CNT_S32   = 3'd4;
    localparam logic [2:0] CNT_RESET = CNT_S16;

    // Input word
    typedef struct packed {
        logic [31:0] sample_bits;
        logic        last_in;
    } f2p_in_t;

    // Output word
    typedef struct packed {
        logic [31:0] pcm_word;
        logic [2:0]  byte_count;
        logic        last_out;
    } f2p_out_t;

    // Decode stage result
    typedef struct packed {
        logic        sign;
        logic        nan;
        logic        ovf;
        logic [23:0] mant;
        logic [5:0]  shamt;
        logic [2:0]  count;
        logic [4:0]  k;
        logic        last;
    } f2p_dec_t;

    // Align stage result: |v| * 2^k as 32.24 fixed point plus sticky
    typedef struct packed {
        logic        sign;
        logic        nan;
        logic        ovf;
        logic [31:0] int_part;
        logic [23:0] frac;
        logic        sticky;
        logic [2:0]  count;
        logic [4:0]  k;
        logic        last;
    } f2p_aln_t;

    // Scale exponent for a sample size: 2^7 (offset 8-bit), 2^15, 2^23, 2^31
    function automatic logic [4:0] scale_exp(input logic [2:0] count);
        logic [4:0] k;
        begin
            case (count)
                CNT_U8:  k = 5'd7;
                CNT_S16: k = 5'd15;
                CNT_S24: k = 5'd23;
                default: k = 5'd31;
            endcase
            return k;
        end
    endfunction

endpackage

// ===== rtl/f2p_decode.sv =====
// ----------------------------------------------------------------------------
// f2p_decode
// Stage 1: split the single-precision sample and work out the alignment shift.
// ----------------------------------------------------------------------------
module f2p_decode
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  f2p_pkg::f2p_in_t   in_data,
    input  logic [2:0]         count,
    output logic               valid,
    output f2p_pkg::f2p_dec_t  dec
);
    import f2p_pkg::*;

    // Biased exponent plus k below which every bit lands in the sticky field,
    // and above which the integer part exceeds 32 bits.
    localparam logic [9:0] SHIFT_BASE = 10'd102;
    localparam logic [9:0] SHIFT_TOP  = 10'd158;

    logic      valid_reg;
    f2p_dec_t  dec_reg;
    f2p_dec_t  dec_next;

    // Decode fields and shift amount
    always_comb
    begin
        logic [7:0] expo;
        logic [7:0] e_eff;
        logic [9:0] sum;
        logic       big;
        expo  = in_data.sample_bits[30:23];
        e_eff = (expo == 8'd0) ? 8'd1 : expo;
        dec_next.sign  = in_data.sample_bits[31];
        dec_next.nan   = (expo == 8'hFF) && (in_data.sample_bits[22:0] != 23'd0);
        dec_next.mant  = {expo != 8'd0, in_data.sample_bits[22:0]};
        dec_next.count = count;
        dec_next.k     = scale_exp(count);
        dec_next.last  = in_data.last_in;
        sum = {2'b00, e_eff} + {5'd0, dec_next.k};
        big = 1'b0;
        if (sum < SHIFT_BASE)
        begin
            dec_next.shamt = 6'd0;
        end
        else if (sum > SHIFT_TOP)
        begin
            dec_next.shamt = 6'd0;
            big = 1'b1;
        end
        else
        begin
            dec_next.shamt = 6'(sum - SHIFT_BASE);
        end
        dec_next.ovf = ((expo == 8'hFF) && (in_data.sample_bits[22:0] == 23'd0)) || big;
    end

    // Advance the stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dec_reg <= dec_next;
        end
    end

    assign valid = valid_reg;
    assign dec   = dec_reg;

endmodule

// ===== rtl/f2p_align.sv =====
// ----------------------------------------------------------------------------
// f2p_align
// Stage 2: shift the mantissa into a 32.24 fixed-point magnitude with sticky.
// ----------------------------------------------------------------------------
module f2p_align
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  f2p_pkg::f2p_dec_t  dec,
    output logic               valid,
    output f2p_pkg::f2p_aln_t  aln
);
    import f2p_pkg::*;

    logic      valid_reg;
    f2p_aln_t  aln_reg;
    f2p_aln_t  aln_next;

    // Barrel shift; bit 48 of the field weighs 2^0
    always_comb
    begin
        logic [79:0] field;
        field = {56'd0, dec.mant} << dec.shamt;
        aln_next.sign     = dec.sign;
        aln_next.nan      = dec.nan;
        aln_next.ovf      = dec.ovf;
        aln_next.int_part = field[79:48];
        aln_next.frac     = field[47:24];
        aln_next.sticky   = |field[23:0];
        aln_next.count    = dec.count;
        aln_next.k        = dec.k;
        aln_next.last     = dec.last;
    end

    // Advance the stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            aln_reg <= aln_next;
        end
    end

    assign valid = valid_reg;
    assign aln   = aln_reg;

endmodule

// ===== rtl/f2p_format.sv =====
// ----------------------------------------------------------------------------
// f2p_format
// Stage 3: round the offset 8-bit case, saturate, negate and pack the word.
// ----------------------------------------------------------------------------
module f2p_format
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  f2p_pkg::f2p_aln_t  aln,
    output logic               valid,
    output f2p_pkg::f2p_out_t  out_word
);
    import f2p_pkg::*;

    logic      valid_reg;
    f2p_out_t  out_reg;
    f2p_out_t  out_next;

    // Offset 8-bit result, with single-precision rounding of the +128 step
    logic [7:0] u8_word;
    always_comb
    begin
        logic       up;
        logic [9:0] sum;
        logic [6:0] n0;
        logic [2:0] j;
        logic [23:0] low_mask;
        up       = 1'b0;
        sum      = 10'd0;
        n0       = 7'd0;
        j        = 3'd0;
        low_mask = 24'd0;
        u8_word  = 8'd0;
        if (!aln.sign)
        begin
            // Grid of [128,256) is 2^-16: round up when the top 17 fraction bits are set
            up  = &aln.frac[23:7];
            sum = {2'b00, aln.int_part[7:0]} + 10'd128 + {9'd0, up};
            if (aln.ovf || (aln.int_part[31:8] != 24'd0) || (sum > 10'd255))
                u8_word = 8'hFF;
            else
                u8_word = sum[7:0];
        end
        else if (aln.ovf || (aln.int_part >= 32'd128))
        begin
            u8_word = 8'd0;
        end
        else if ((aln.frac == 24'd0) && !aln.sticky)
        begin
            u8_word = 8'(9'd128 - {2'b00, aln.int_part[6:0]});
        end
        else
        begin
            n0 = 7'd127 - aln.int_part[6:0];
            // Binade of the sum sets the rounding grid
            for (int i = 0; i < 7; i++)
            begin
                if (n0[i])
                    j = 3'(i);
            end
            low_mask = (24'd1 << j) - 24'd1;
            up = (n0 != 7'd0) && ((aln.frac >> ({1'b0, j} + 4'd1)) == 24'd0) &&
                 (!aln.frac[j] || (((aln.frac & low_mask) == 24'd0) && !aln.sticky));
            u8_word = {1'b0, n0} + {7'd0, up};
        end
    end

    // Signed result: truncate, saturate to [-2^k, 2^k-1], keep the low bytes
    logic [31:0] s_word;
    always_comb
    begin
        logic [31:0] lim;
        logic [31:0] mask;
        lim  = 32'd1 << aln.k;
        mask = 32'hFFFF_FFFF >> (5'd31 - aln.k);
        if (!aln.sign)
            s_word = (aln.ovf || (aln.int_part >= lim)) ? (lim - 32'd1) : aln.int_part;
        else if (aln.ovf || (aln.int_part > lim))
            s_word = lim;
        else
            s_word = (~aln.int_part + 32'd1) & mask;
    end

    // Select by sample size
    always_comb
    begin
        out_next.last_out   = aln.last;
        out_next.byte_count = aln.count;
        out_next.pcm_word   = 32'd0;
        case (aln.count) inside
            CNT_U8:
            begin
                if (!aln.nan)
                    out_next.pcm_word = {24'd0, u8_word};
            end
            CNT_S16, CNT_S24, CNT_S32:
            begin
                if (!aln.nan)
                    out_next.pcm_word = s_word;
            end
            default:
            begin
                out_next.byte_count = 3'd0;
            end
        endcase
    end

    // Hold the output word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign valid    = valid_reg;
    assign out_word = out_reg;

endmodule

// ===== rtl/float_to_pcm_packer.sv =====
// ----------------------------------------------------------------------------
// float_to_pcm_packer
// Converts single-precision audio samples to saturated little-endian PCM.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one float sample word and a last flag;
//   out_valid/out_stall/out_data return the PCM word, its byte count and the
//   last flag. A word moves on a clock edge with valid high and stall low.
//   cfg_valid/cfg_ready/cfg_data set the sample size (1 = offset 8-bit,
//   2/3/4 = signed 16/24/32-bit); write it only while the block is empty.
//   The path from input acceptance to out_valid runs through the decode, align and
//   format registers. Throughput is one word per cycle while out_stall is low.
//   Each stage moves when the one after it is empty or moving, so bubbles
//   close up; while out_stall is high the output word holds and the front
//   stages keep filling until full, after which in_stall rises.
//   Reset empties the pipeline and sets the sample size to 16-bit.
//   NaN gives a zero word; an unsupported size gives zero with byte count 0.
// ----------------------------------------------------------------------------
module float_to_pcm_packer
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  f2p_pkg::f2p_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output f2p_pkg::f2p_out_t out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_data
);
    import f2p_pkg::*;

    logic [2:0] sample_bytes_reg;
    logic       v1;
    logic       v2;
    logic       v3;
    logic       rdy1;
    logic       rdy2;
    logic       rdy3;
    f2p_dec_t   dec;
    f2p_aln_t   aln;

    // Sample-size register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_bytes_reg <= CNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            sample_bytes_reg <= cfg_data;
        end
    end

    // Stage enables: advance into an empty or draining stage
    assign rdy3     = !v3 || !out_stall;
    assign rdy2     = !v2 || rdy3;
    assign rdy1     = !v1 || rdy2;
    assign in_stall = !rdy1;

    f2p_decode u_decode
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (rdy1),
        .in_valid (in_valid),
        .in_data  (in_data),
        .count    (sample_bytes_reg),
        .valid    (v1),
        .dec      (dec)
    );

    f2p_align u_align
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (rdy2),
        .in_valid (v1),
        .dec      (dec),
        .valid    (v2),
        .aln      (aln)
    );

    f2p_format u_format
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (rdy3),
        .in_valid (v2),
        .aln      (aln),
        .valid    (v3),
        .out_word (out_data)
    );

    assign out_valid = v3;

    // An accepted word occupies the first stage next cycle
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> v1)
        else $error("accepted word missing from decode stage");

    // A full stalled pipeline keeps every stage occupied
    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        v1 && v2 && v3 && out_stall |=> v1 && v2 && v3)
        else $error("stalled pipeline dropped a word");

    // Offset 8-bit words use the low byte only
    a_u8_width: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.byte_count == CNT_U8) |-> out_data.pcm_word[31:8] == 24'd0)
        else $error("8-bit word has high bytes set");

    // Unsupported size flags zero output
    a_bad_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.byte_count == 3'd0) |-> out_data.pcm_word == 32'd0)
        else $error("error word is not zero");

    // Configuration write lands in the register
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> sample_bytes_reg == $past(cfg_data))
        else $error("sample size write lost");

endmodule
